FILE: src/bir_pkg.sv
// shared constants and types for the bilinear image rescaler
package bir_pkg;

   localparam int MAX_SRC_WIDTH_DEF  = 512;
   localparam int MAX_SRC_HEIGHT_DEF = 512;
   localparam int FRACTION_BITS_DEF  = 16;

   localparam int POS_W   = 10;
   localparam int STEP_W  = 24;
   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 4 * CHAN_W;
   localparam int PROD_W  = POS_W + STEP_W;
   localparam int CSR_W   = STEP_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [POS_W-1:0]  SIZE_RESET = POS_W'(512);
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_STEP_X     = 2'd2,
      CSR_STEP_Y     = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_REQUEST = 1'b1
   } operation_type;

endpackage

FILE: src/bir_ram.sv
// generic simple dual port ram with registered read
module bir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

FILE: src/bilinear_image_rescaler.sv
// Bilinear image rescaler. Load items (operation 0) write one source RGBA pixel into a frame
// store split into four banks by column and row parity, so the four neighbours of any source
// position come out of one read of all four banks. Request items (operation 1) give one
// blended pixel each, loads give none. The pipeline takes one item per clock while no result
// is stalled. Its steps: scale multiply, neighbour map and bank access, bank read, horizontal
// blend, vertical blend, rounding into the output register. The whole pipeline, bubbles
// included, holds while a waiting result is stalled, and the input stalls with it. No clearing
// pass: a request must only touch pixels that were loaded. Size registers clamp to 1..MAX, the
// position clamps to the last column and row.
module bilinear_image_rescaler #(
   parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int FRACTION_BITS  = bir_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bir_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bir_pkg::CSR_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [bir_pkg::POS_W-1:0]     req_pos_x,
   input  logic [bir_pkg::POS_W-1:0]     req_pos_y,
   input  logic [bir_pkg::CHAN_W-1:0]    req_in_red,
   input  logic [bir_pkg::CHAN_W-1:0]    req_in_green,
   input  logic [bir_pkg::CHAN_W-1:0]    req_in_blue,
   input  logic [bir_pkg::CHAN_W-1:0]    req_in_alpha,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bir_pkg::POS_W-1:0]     rsp_dst_x,
   output logic [bir_pkg::POS_W-1:0]     rsp_dst_y,
   output logic [bir_pkg::CHAN_W-1:0]    rsp_out_red,
   output logic [bir_pkg::CHAN_W-1:0]    rsp_out_green,
   output logic [bir_pkg::CHAN_W-1:0]    rsp_out_blue,
   output logic [bir_pkg::CHAN_W-1:0]    rsp_out_alpha
);
   import bir_pkg::*;

   localparam int F    = FRACTION_BITS;
   localparam int XW   = $clog2(MAX_SRC_WIDTH);
   localparam int YW   = $clog2(MAX_SRC_HEIGHT);
   localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
   localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int ABW  = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
   localparam int WGT_W = F + 1;
   localparam int TOP_W = F + CHAN_W;
   localparam int SUM_W = 2 * F + CHAN_W;
   localparam logic [WGT_W-1:0] ONE_Q = WGT_W'(1) << F;
   localparam logic [SUM_W:0]   HALF_LSB = (SUM_W + 1)'(1) << (2 * F - 1);

   // configuration registers
   logic [POS_W-1:0]  src_width_ff, src_height_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_RESET;
         src_height_ff <= SIZE_RESET;
         step_x_ff     <= STEP_RESET;
         step_y_ff     <= STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_ff  <= csr_write_data[POS_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_write_data[POS_W-1:0];
            CSR_STEP_X:     step_x_ff     <= csr_write_data;
            CSR_STEP_Y:     step_y_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !rsp_valid | !rsp_stall;
   assign req_stall = !en;

   // stage 1: scale multiply
   logic                v1_ff, op1_ff;
   logic [POS_W-1:0]    dx1_ff, dy1_ff;
   logic [PIXEL_W-1:0]  pix1_ff;
   logic [PROD_W-1:0]   px1_ff, py1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff  <= req_operation;
         dx1_ff  <= req_pos_x;
         dy1_ff  <= req_pos_y;
         pix1_ff <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
         px1_ff  <= PROD_W'(req_pos_x) * PROD_W'(step_x_ff);
         py1_ff  <= PROD_W'(req_pos_y) * PROD_W'(step_y_ff);
      end
   end

   // stage 2: neighbour map, bank access
   int unsigned w_size, h_size;
   logic [XW-1:0] last_x, x0, x1;
   logic [YW-1:0] last_y, y0, y1;
   logic          edge_x, edge_y;
   logic [F-1:0]  fx, fy;
   logic          load_ok, do_load, do_read;

   always_comb begin
      w_size = (src_width_ff == '0) ? 1 :
               (32'(src_width_ff) > MAX_SRC_WIDTH ? MAX_SRC_WIDTH : 32'(src_width_ff));
      h_size = (src_height_ff == '0) ? 1 :
               (32'(src_height_ff) > MAX_SRC_HEIGHT ? MAX_SRC_HEIGHT : 32'(src_height_ff));
      last_x = XW'(w_size - 1);
      last_y = YW'(h_size - 1);
      edge_x = (px1_ff >> F) >= PROD_W'(last_x);
      edge_y = (py1_ff >> F) >= PROD_W'(last_y);
      x0 = edge_x ? last_x : XW'(px1_ff >> F);
      y0 = edge_y ? last_y : YW'(py1_ff >> F);
      x1 = edge_x ? last_x : x0 + XW'(1);
      y1 = edge_y ? last_y : y0 + YW'(1);
      fx = edge_x ? '0 : px1_ff[F-1:0];
      fy = edge_y ? '0 : py1_ff[F-1:0];
      load_ok = (32'(dx1_ff) < MAX_SRC_WIDTH) && (32'(dy1_ff) < MAX_SRC_HEIGHT);
      do_load = en && v1_ff && (op1_ff == OP_LOAD) && load_ok;
      do_read = en && v1_ff && (op1_ff == OP_REQUEST);
   end

   logic [PIXEL_W-1:0] bank_data [4];

   for (genvar q = 0; q < 4; q++) begin : g_bank
      localparam bit XQ = (q % 2) == 1;
      localparam bit YQ = (q / 2) == 1;
      logic [XW-1:0]  col;
      logic [YW-1:0]  row;
      logic [ABW-1:0] rd_addr, wr_addr;
      logic           wr_en;

      assign col = (x0[0] == XQ) ? x0 : x1;
      assign row = (y0[0] == YQ) ? y0 : y1;
      assign rd_addr = ABW'((32'(row) >> 1) * HALF_W + (32'(col) >> 1));
      assign wr_addr = ABW'((32'(dy1_ff) >> 1) * HALF_W + (32'(dx1_ff) >> 1));
      assign wr_en   = do_load && (dx1_ff[0] == XQ) && (dy1_ff[0] == YQ);

      bir_ram #(
         .WIDTH (PIXEL_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (pix1_ff),
         .rd_en   (do_read),
         .rd_addr (rd_addr),
         .rd_data (bank_data[q])
      );
   end

   logic             v2_ff;
   logic [POS_W-1:0] dx2_ff, dy2_ff;
   logic [F-1:0]     fx2_ff, fy2_ff;
   logic             x0p_ff, x1p_ff, y0p_ff, y1p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff && (op1_ff == OP_REQUEST);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         fx2_ff <= fx;
         fy2_ff <= fy;
         x0p_ff <= x0[0];
         x1p_ff <= x1[0];
         y0p_ff <= y0[0];
         y1p_ff <= y1[0];
      end
   end

   // stage 3: horizontal blend
   logic [PIXEL_W-1:0] p00, p01, p10, p11;
   logic [WGT_W-1:0]   wx1, wx0;
   logic [TOP_W-1:0]   top_in [4];
   logic [TOP_W-1:0]   bot_in [4];

   always_comb begin
      p00 = bank_data[{y0p_ff, x0p_ff}];
      p01 = bank_data[{y0p_ff, x1p_ff}];
      p10 = bank_data[{y1p_ff, x0p_ff}];
      p11 = bank_data[{y1p_ff, x1p_ff}];
      wx1 = WGT_W'(fx2_ff);
      wx0 = ONE_Q - wx1;
      for (int c = 0; c < 4; c++) begin
         top_in[c] = TOP_W'(TOP_W'(p00[c*CHAN_W +: CHAN_W]) * TOP_W'(wx0)
                          + TOP_W'(p01[c*CHAN_W +: CHAN_W]) * TOP_W'(wx1));
         bot_in[c] = TOP_W'(TOP_W'(p10[c*CHAN_W +: CHAN_W]) * TOP_W'(wx0)
                          + TOP_W'(p11[c*CHAN_W +: CHAN_W]) * TOP_W'(wx1));
      end
   end

   logic             v3_ff;
   logic [POS_W-1:0] dx3_ff, dy3_ff;
   logic [F-1:0]     fy3_ff;
   logic [TOP_W-1:0] top3_ff [4];
   logic [TOP_W-1:0] bot3_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         fy3_ff  <= fy2_ff;
         top3_ff <= top_in;
         bot3_ff <= bot_in;
      end
   end

   // stage 4: vertical blend
   logic [WGT_W-1:0] wy1, wy0;
   logic [SUM_W-1:0] sum_in [4];

   always_comb begin
      wy1 = WGT_W'(fy3_ff);
      wy0 = ONE_Q - wy1;
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = SUM_W'(SUM_W'(top3_ff[c]) * SUM_W'(wy0)
                          + SUM_W'(bot3_ff[c]) * SUM_W'(wy1));
      end
   end

   logic             v4_ff;
   logic [POS_W-1:0] dx4_ff, dy4_ff;
   logic [SUM_W-1:0] sum4_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         sum4_ff <= sum_in;
      end
   end

   // stage 5: round half up, saturate
   logic [CHAN_W-1:0] chan_in [4];
   logic [SUM_W:0]    rounded;

   always_comb begin
      rounded = '0;
      for (int c = 0; c < 4; c++) begin
         rounded = ((SUM_W + 1)'(sum4_ff[c]) + HALF_LSB) >> (2 * F);
         chan_in[c] = (rounded > (SUM_W + 1)'(255)) ? '1 : rounded[CHAN_W-1:0];
      end
   end

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [CHAN_W-1:0] rsp_chan_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_x_ff    <= dx4_ff;
         rsp_y_ff    <= dy4_ff;
         rsp_chan_ff <= chan_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dst_x     = rsp_x_ff;
   assign rsp_dst_y     = rsp_y_ff;
   assign rsp_out_red   = rsp_chan_ff[0];
   assign rsp_out_green = rsp_chan_ff[1];
   assign rsp_out_blue  = rsp_chan_ff[2];
   assign rsp_out_alpha = rsp_chan_ff[3];

   // a load never turns into a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      en && v1_ff && (op1_ff == OP_LOAD) |=> !v2_ff)
      else $error("load item entered the blend pipeline");

   // edge clamp forces zero horizontal fraction
   a_edge_x_frac: assert property (@(posedge clock) disable iff (reset)
      en && v1_ff && (op1_ff == OP_REQUEST) && edge_x |=> fx2_ff == '0)
      else $error("nonzero fraction at horizontal edge");

   // edge clamp forces zero vertical fraction
   a_edge_y_frac: assert property (@(posedge clock) disable iff (reset)
      en && v1_ff && (op1_ff == OP_REQUEST) && edge_y |=> fy2_ff == '0)
      else $error("nonzero fraction at vertical edge");

   // a held result freezes the pipeline behind it
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(v4_ff) && $stable(v3_ff) && $stable(v2_ff))
      else $error("pipeline moved while result was stalled");
endmodule

FILE: test/bilinear_image_rescaler_tb.sv
// self-checking testbench for the bilinear image rescaler
`timescale 1ns / 1ps

module bilinear_image_rescaler_tb;
   import bir_pkg::*;

   localparam int FRAME_W = MAX_SRC_WIDTH_DEF;
   localparam int FRAME_H = MAX_SRC_HEIGHT_DEF;
   localparam int FRAC    = FRACTION_BITS_DEF;
   localparam longint unsigned ONE = 64'd1 << FRAC;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_type;

   class pixel_checker;
      pixel_type pending[$];
      int        errors = 0;

      task report(string what);
         $display("error at %0t: %s", $realtime, what);
         errors++;
      endtask

      function void note(pixel_type p);
         pending.push_back(p);
      endfunction

      task check(pixel_type got);
         pixel_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected pixel (%0d,%0d)", got.x, got.y));
            return;
         end
         want = pending.pop_front();
         if (got.x !== want.x) report($sformatf("dst_x %0d want %0d", got.x, want.x));
         if (got.y !== want.y) report($sformatf("dst_y %0d want %0d", got.y, want.y));
         if (got.red !== want.red)
            report($sformatf("red %0d want %0d at (%0d,%0d)", got.red, want.red, want.x, want.y));
         if (got.green !== want.green)
            report($sformatf("green %0d want %0d at (%0d,%0d)", got.green, want.green,
                             want.x, want.y));
         if (got.blue !== want.blue)
            report($sformatf("blue %0d want %0d at (%0d,%0d)", got.blue, want.blue,
                             want.x, want.y));
         if (got.alpha !== want.alpha)
            report($sformatf("alpha %0d want %0d at (%0d,%0d)", got.alpha, want.alpha,
                             want.x, want.y));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SRC_WIDTH;
   logic [CSR_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_operation = OP_LOAD;
   logic [POS_W-1:0]     req_pos_x = '0;
   logic [POS_W-1:0]     req_pos_y = '0;
   logic [CHAN_W-1:0]    req_in_red = '0;
   logic [CHAN_W-1:0]    req_in_green = '0;
   logic [CHAN_W-1:0]    req_in_blue = '0;
   logic [CHAN_W-1:0]    req_in_alpha = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [POS_W-1:0]     rsp_dst_x;
   logic [POS_W-1:0]     rsp_dst_y;
   logic [CHAN_W-1:0]    rsp_out_red;
   logic [CHAN_W-1:0]    rsp_out_green;
   logic [CHAN_W-1:0]    rsp_out_blue;
   logic [CHAN_W-1:0]    rsp_out_alpha;

   bilinear_image_rescaler dut (.*);

   always #5 clock = ~clock;

   pixel_checker      board = new();
   logic [PIXEL_W-1:0] model_frame [0:FRAME_W*FRAME_H-1];
   logic [POS_W-1:0]   model_width  = SIZE_RESET;
   logic [POS_W-1:0]   model_height = SIZE_RESET;
   logic [STEP_W-1:0]  model_step_x = STEP_RESET;
   logic [STEP_W-1:0]  model_step_y = STEP_RESET;
   bit                 quiet = 0;

   function automatic int eff_size(logic [POS_W-1:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
   endfunction

   function automatic void map_axis(logic [POS_W-1:0] d, logic [STEP_W-1:0] step, int size,
                                    output int i0, output int i1, output longint unsigned f);
      logic [PROD_W-1:0] p;
      longint unsigned   ip;
      p  = PROD_W'(d) * PROD_W'(step);
      ip = p >> FRAC;
      if (ip >= size - 1) begin
         i0 = size - 1;
         i1 = size - 1;
         f  = 0;
      end else begin
         i0 = int'(ip);
         i1 = int'(ip) + 1;
         f  = p & (ONE - 1);
      end
   endfunction

   function automatic pixel_type blend_pixel(logic [POS_W-1:0] dx, logic [POS_W-1:0] dy);
      pixel_type         o;
      int                x0, x1, y0, y1;
      longint unsigned   fx, fy, top, bot, sum, r;
      logic [PIXEL_W-1:0] p00, p10, p01, p11;
      logic [CHAN_W-1:0] ch [4];
      map_axis(dx, model_step_x, eff_size(model_width, FRAME_W), x0, x1, fx);
      map_axis(dy, model_step_y, eff_size(model_height, FRAME_H), y0, y1, fy);
      p00 = model_frame[y0*FRAME_W + x0];
      p10 = model_frame[y0*FRAME_W + x1];
      p01 = model_frame[y1*FRAME_W + x0];
      p11 = model_frame[y1*FRAME_W + x1];
      for (int c = 0; c < 4; c++) begin
         top = p00[c*8 +: 8] * (ONE - fx) + p10[c*8 +: 8] * fx;
         bot = p01[c*8 +: 8] * (ONE - fx) + p11[c*8 +: 8] * fx;
         sum = top * (ONE - fy) + bot * fy;
         r   = (sum + (64'd1 << (2*FRAC - 1))) >> (2*FRAC);
         ch[c] = (r > 255) ? 8'd255 : r[7:0];
      end
      o.x = dx;
      o.y = dy;
      o.red = ch[0];
      o.green = ch[1];
      o.blue = ch[2];
      o.alpha = ch[3];
      return o;
   endfunction

   // waits out the pipeline, then writes all four registers
   task automatic write_regs(logic [POS_W-1:0] w, logic [POS_W-1:0] h,
                             logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy);
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SRC_WIDTH;  csr_write_data <= CSR_W'(w);  @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT; csr_write_data <= CSR_W'(h);  @(posedge clock);
      csr_index <= CSR_STEP_X;     csr_write_data <= sx;         @(posedge clock);
      csr_index <= CSR_STEP_Y;     csr_write_data <= sy;         @(posedge clock);
      csr_write_enable <= 1'b0;
      model_width = w;
      model_height = h;
      model_step_x = sx;
      model_step_y = sy;
   endtask

   task automatic send(operation_type op, int x, int y, logic [PIXEL_W-1:0] v);
      while (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_pos_x <= POS_W'(x);
      req_pos_y <= POS_W'(y);
      {req_in_alpha, req_in_blue, req_in_green, req_in_red} <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_REQUEST)
         board.note(blend_pixel(POS_W'(x), POS_W'(y)));
      else if (x < FRAME_W && y < FRAME_H)
         model_frame[y*FRAME_W + x] = v;
   endtask

   task automatic load_region(int w, int h);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            send(OP_LOAD, x, y, $urandom);
   endtask

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(4))
         0: return '0;
         1: return STEP_RESET;
         2: return STEP_W'($urandom_range(65535));
         3: return STEP_W'($urandom_range(4 << FRAC));
         default: return STEP_W'($urandom);
      endcase
   endfunction

   // random mix of requests, overwrites inside the region and loads off the store
   task automatic mixed_traffic(int n, int w, int h);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 12)
            send(OP_LOAD, $urandom_range(w - 1), $urandom_range(h - 1), $urandom);
         else if (k < 18)
            send(OP_LOAD, $urandom_range(1023, FRAME_W), $urandom_range(1023), $urandom);
         else if (k < 22)
            send(OP_LOAD, $urandom_range(1023), $urandom_range(1023, FRAME_H), $urandom);
         else if (k < 60)
            send(OP_REQUEST, $urandom_range(1023), $urandom_range(1023), $urandom);
         else
            send(OP_REQUEST, $urandom_range(31), $urandom_range(31), $urandom);
      end
   endtask

   // result side: check on accept, then pick the next stall
   initial begin
      pixel_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_dst_x, rsp_dst_y, rsp_out_red, rsp_out_green, rsp_out_blue,
                    rsp_out_alpha};
            board.check(got);
         end
         rsp_stall <= !quiet && $urandom_range(99) < 11;
      end
   end

   initial begin
      #3_000_000;
      $display("bilinear_image_rescaler: mismatch");
      $finish;
   end

   initial begin
      int w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // small frame, unit step, corner and past-edge requests
      write_regs(4, 3, STEP_RESET, STEP_RESET);
      send(OP_LOAD, 0, 0, 32'h0000_0000);
      send(OP_LOAD, 3, 2, 32'hFFFF_FFFF);
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 4; x++)
            if (!(x == 0 && y == 0) && !(x == 3 && y == 2))
               send(OP_LOAD, x, y, $urandom);
      send(OP_REQUEST, 0, 0, '0);
      send(OP_REQUEST, 3, 2, '1);
      send(OP_REQUEST, 1023, 1023, '0);
      send(OP_REQUEST, 2, 1, '0);
      // half step gives true blends
      write_regs(4, 3, STEP_W'(ONE / 2), STEP_W'(ONE / 2));
      send(OP_REQUEST, 1, 1, '0);
      send(OP_REQUEST, 5, 3, '0);
      send(OP_REQUEST, 7, 5, '0);
      // zero size counts as one, zero step, loads off the store are dropped
      write_regs(0, 0, '1, '0);
      send(OP_LOAD, 0, 0, $urandom);
      send(OP_LOAD, 1023, 1023, $urandom);
      send(OP_LOAD, 600, 0, $urandom);
      send(OP_REQUEST, 1023, 1023, '0);
      send(OP_REQUEST, 5, 0, '0);

      // oversized width register clamps to the full frame width
      write_regs(1023, 1, pick_step(), pick_step());
      load_region(FRAME_W, 1);
      mixed_traffic(30, FRAME_W, 1);
      write_regs(1, 1023, STEP_W'($urandom_range(3 << FRAC)), pick_step());
      load_region(1, FRAME_H);
      mixed_traffic(30, 1, FRAME_H);

      for (int ph = 0; ph < 4; ph++) begin
         w = $urandom_range(16, 1);
         h = $urandom_range(12, 1);
         quiet = (ph == 2);
         write_regs(POS_W'(w), POS_W'(h), pick_step(), pick_step());
         load_region(w, h);
         mixed_traffic(25, w, h);
      end
      quiet = 0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.pending.size() != 0)
         board.report($sformatf("%0d pixels never arrived", board.pending.size()));
      if (board.errors == 0)
         $display("bilinear_image_rescaler: match");
      else
         $display("bilinear_image_rescaler: mismatch");
      $finish;
   end

endmodule
